[sv/cyl_pkg.sv]
// Shared widths, default fraction bits and register indices for the cylinder
// support point block. No dependencies.
`default_nettype none
package cyl_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned RADIUS_W        = 31;
  localparam int unsigned HALF_HEIGHT_W   = 31;
  localparam int unsigned EPSILON_W       = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned ROOT_W          = 32;
  localparam int unsigned QUO_W           = 31;
  localparam int unsigned DEFAULT_FRAC_BITS = 16;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 2'd2;

endpackage
`default_nettype wire

[sv/cyl_if.sv]
// Channel interfaces: direction input, support point output, config writes.
// Depends on cyl_pkg.
`default_nettype none

interface cyl_dir_if import cyl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] dir_x;
  logic signed [DATA_W-1:0] dir_y;
  logic signed [DATA_W-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cyl_point_if import cyl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cyl_cfg_if import cyl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/cyl_sqrt.sv]
// Pipelined integer square root, one result bit per stage (32 stages).
// Carries a sideband word alongside. Depends on cyl_pkg.
`default_nettype none
module cyl_sqrt import cyl_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  valid_in,
  input  wire logic [2*ROOT_W-1:0]   value,
  input  wire logic [SIDE_W-1:0]     side_in,
  output logic                       valid_out,
  output logic [ROOT_W-1:0]          root,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]    rem   [0:ROOT_W];
  logic [ROOT_W-1:0]   res   [0:ROOT_W];
  logic [2*ROOT_W-1:0] rest  [0:ROOT_W];
  logic [SIDE_W-1:0]   side  [0:ROOT_W];
  logic                vld   [0:ROOT_W];

  assign rem[0]  = '0;
  assign res[0]  = '0;
  assign rest[0] = value;
  assign side[0] = side_in;
  assign vld[0]  = valid_in;

  // One digit step per stage: bring down two bits, try subtracting 4q+1
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    always_comb begin
      rem_sh = {rem[k], rest[k][2*ROOT_W-1 -: 2]};
      trial  = {2'b00, res[k], 2'b01};
      ge     = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        res[k+1]  <= {res[k][ROOT_W-2:0], ge};
        rest[k+1] <= {rest[k][2*ROOT_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign valid_out = vld[ROOT_W];
  assign root      = res[ROOT_W];
  assign side_out  = side[ROOT_W];

endmodule
`default_nettype wire

[sv/cyl_div.sv]
// Pipelined restoring divider, one quotient bit per stage (31 stages).
// Needs num < den * 2^31. Carries a sideband word. Depends on cyl_pkg.
`default_nettype none
module cyl_div import cyl_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [ROOT_W+QUO_W-1:0]    num,
  input  wire logic [ROOT_W-1:0]          den,
  input  wire logic [SIDE_W-1:0]          side_in,
  output logic                            valid_out,
  output logic [QUO_W-1:0]                quo,
  output logic [SIDE_W-1:0]               side_out
);

  logic [ROOT_W-1:0] rem  [0:QUO_W];
  logic [QUO_W-1:0]  low  [0:QUO_W];
  logic [ROOT_W-1:0] dv   [0:QUO_W];
  logic [QUO_W-1:0]  q    [0:QUO_W];
  logic [SIDE_W-1:0] side [0:QUO_W];
  logic              vld  [0:QUO_W];

  // Upper half is already below the divisor, so start from it
  assign rem[0]  = num[ROOT_W+QUO_W-1:QUO_W];
  assign low[0]  = num[QUO_W-1:0];
  assign dv[0]   = den;
  assign q[0]    = '0;
  assign side[0] = side_in;
  assign vld[0]  = valid_in;

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [ROOT_W:0] rs;
    logic            ge;
    always_comb begin
      rs = {rem[k], low[k][QUO_W-1]};
      ge = rs >= {1'b0, dv[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? ROOT_W'(rs - {1'b0, dv[k]}) : ROOT_W'(rs);
        low[k+1]  <= {low[k][QUO_W-2:0], 1'b0};
        dv[k+1]   <= dv[k];
        q[k+1]    <= {q[k][QUO_W-2:0], ge};
        side[k+1] <= side[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign valid_out = vld[QUO_W];
  assign quo       = q[QUO_W];
  assign side_out  = side[QUO_W];

endmodule
`default_nettype wire

[sv/cylinder_support_point_top.sv]
// Support point of a Y-axis cylinder: input magnitudes, squares, root, scale, divide.
// Depends on cyl_pkg, cyl_if, cyl_sqrt and cyl_div.
//
// Usage:
//   dir   : one direction (dir_x, dir_y, dir_z), signed Q16.16, per transfer.
//   point : one support point (point_x, point_y, point_z) per direction, in order.
//   cfg   : register writes (index 0 radius, 1 half_height, 2 epsilon); always
//           ready; write only while no direction is in flight. Other indices
//           are ignored.
// Pipeline: from the dir transfer to point valid, 3 input stages, 32
//   square-root stages, 1 scaling multiply, 31 divide stages, 1 output.
// Throughput: one direction per cycle while point is not stalled. The square
//   root and both divisions are fully pipelined, one result bit per stage.
// Reset: all stage valid bits clear; registers return to radius 1.0,
//   half_height 0.5, epsilon one LSB.
// Stall: while point is valid and not taken, the whole pipeline holds and
//   dir.ready is low; nothing is lost or repeated. Bubbles move on freely
//   whenever the output stage is empty or being taken.
`default_nettype none
module cylinder_support_point_top import cyl_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cyl_dir_if.sink     dir,
  cyl_point_if.source point,
  cyl_cfg_if.sink     cfg
);

  localparam int unsigned SQ_W   = 2 * DATA_W;
  localparam int unsigned PROD_W = ROOT_W + QUO_W;
  localparam int unsigned SIDE_W = 2 * DATA_W + 3;

  logic                     en;
  logic [RADIUS_W-1:0]      radius;
  logic [HALF_HEIGHT_W-1:0] half_height;
  logic [EPSILON_W-1:0]     epsilon;

  // Global advance: move when the output stage is free or being taken
  assign en        = !point.valid || point.ready;
  assign dir.ready = en;
  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_W'(1) << FRAC_BITS;
      half_height <= HALF_HEIGHT_W'(1) << (FRAC_BITS - 1);
      epsilon     <= EPSILON_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RADIUS:      radius      <= cfg.data[RADIUS_W-1:0];
        REG_HALF_HEIGHT: half_height <= cfg.data[HALF_HEIGHT_W-1:0];
        REG_EPSILON:     epsilon     <= cfg.data[EPSILON_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes and signs
  logic              v1, nx1, ny1, nz1;
  logic [DATA_W-1:0] ax1, az1;
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= dir.dir_x[DATA_W-1] ? DATA_W'(-dir.dir_x) : DATA_W'(dir.dir_x);
      az1 <= dir.dir_z[DATA_W-1] ? DATA_W'(-dir.dir_z) : DATA_W'(dir.dir_z);
      nx1 <= dir.dir_x[DATA_W-1];
      ny1 <= dir.dir_y[DATA_W-1];
      nz1 <= dir.dir_z[DATA_W-1];
    end
  end

  // Stage 2: squares
  logic              v2, nx2, ny2, nz2;
  logic [DATA_W-1:0] ax2, az2;
  logic [SQ_W-1:0]   sqx2, sqz2;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= SQ_W'(ax1) * SQ_W'(ax1);
      sqz2 <= SQ_W'(az1) * SQ_W'(az1);
      ax2  <= ax1;
      az2  <= az1;
      nx2  <= nx1;
      ny2  <= ny1;
      nz2  <= nz1;
    end
  end

  // Stage 3: sum of squares, at most 2^63
  logic              v3, nx3, ny3, nz3;
  logic [DATA_W-1:0] ax3, az3;
  logic [SQ_W-1:0]   sum3;
  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= sqx2 + sqz2;
      ax3  <= ax2;
      az3  <= az2;
      nx3  <= nx2;
      ny3  <= ny2;
      nz3  <= nz2;
    end
  end

  // Valid bits of the input stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= dir.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Radial length
  logic              vs;
  logic [ROOT_W-1:0] s_root;
  logic [SIDE_W-1:0] side_s;
  logic [DATA_W-1:0] axs, azs;
  logic              nxs, nys, nzs;

  cyl_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v3),
    .value     (sum3),
    .side_in   ({ax3, az3, nx3, ny3, nz3}),
    .valid_out (vs),
    .root      (s_root),
    .side_out  (side_s)
  );
  assign {axs, azs, nxs, nys, nzs} = side_s;

  // Stage 4: scale by radius, decide axial
  logic              v4, nx4, ny4, nz4, radial4;
  logic [PROD_W-1:0] prx4, prz4;
  logic [ROOT_W-1:0] s4;
  always_ff @(posedge clk) begin
    if (en) begin
      prx4    <= PROD_W'(axs) * PROD_W'(radius);
      prz4    <= PROD_W'(azs) * PROD_W'(radius);
      s4      <= s_root;
      radial4 <= s_root > ROOT_W'(epsilon);
      nx4     <= nxs;
      ny4     <= nys;
      nz4     <= nzs;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vs;
    end
  end

  // Radial divisions
  logic             vdx, vdz, nxd, nyd, radd, nzd;
  logic [QUO_W-1:0] qx, qz;

  cyl_div #(.SIDE_W(3)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v4),
    .num       (prx4),
    .den       (s4),
    .side_in   ({nx4, ny4, radial4}),
    .valid_out (vdx),
    .quo       (qx),
    .side_out  ({nxd, nyd, radd})
  );

  cyl_div #(.SIDE_W(1)) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v4),
    .num       (prz4),
    .den       (s4),
    .side_in   (nz4),
    .valid_out (vdz),
    .quo       (qz),
    .side_out  (nzd)
  );

  // Output stage: apply signs, drop the radial part for axial directions
  logic [DATA_W-1:0] mx, mz, my;
  always_comb begin
    mx = radd ? {1'b0, qx} : '0;
    mz = radd ? {1'b0, qz} : '0;
    my = {1'b0, half_height};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point.point_x <= nxd ? -$signed(mx) : $signed(mx);
      point.point_y <= nyd ? -$signed(my) : $signed(my);
      point.point_z <= nzd ? -$signed(mz) : $signed(mz);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (en) begin
      point.valid <= vdx;
    end
  end

  // Magnitudes for checking
  logic [DATA_W-1:0] chk_px, chk_pz;
  assign chk_px = point.point_x[DATA_W-1] ? DATA_W'(-point.point_x) : DATA_W'(point.point_x);
  assign chk_pz = point.point_z[DATA_W-1] ? DATA_W'(-point.point_z) : DATA_W'(point.point_z);

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (rst) vdx == vdz)
    else $error("divider lanes out of step");

  a_radial_bound: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (chk_px <= {1'b0, radius}) && (chk_pz <= {1'b0, radius}))
    else $error("radial output exceeds radius");

  a_height: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.point_y == $signed({1'b0, half_height}))
                 || (point.point_y == -$signed({1'b0, half_height})))
    else $error("point_y is not plus or minus half height");

  a_reset_empty: assert property (@(posedge clk) rst |=> !point.valid && !v1 && !v4)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

[bench/cylinder_support_point_top_tb.sv]
// Self-checking bench for the cylinder support point block: drives directions,
// predicts support points and compares them field by field.
// Depends on cyl_pkg, cyl_if and cylinder_support_point_top.
`timescale 1ns / 1ps
module cylinder_support_point_top_tb;
  import cyl_pkg::*;

  localparam int LATENCY = 68;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_t;

  // Directed stimulus row; known flags whether a typed-in result applies
  typedef struct {
    vec_t dir;
    bit   known;
    vec_t pt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cyl_dir_if   dir_ch ();
  cyl_point_if pt_ch ();
  cyl_cfg_if   cfg_ch ();

  cylinder_support_point_top u_top (
    .clk  (clk),
    .rst  (rst),
    .dir  (dir_ch.sink),
    .point(pt_ch.source),
    .cfg  (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  logic [RADIUS_W-1:0]      cyl_radius;
  logic [HALF_HEIGHT_W-1:0] cyl_half_h;
  logic [EPSILON_W-1:0]     cyl_eps;

  vec_t pending_points[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag32(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? {32'd0, -v} : {32'd0, v};
  endfunction

  function automatic vec_t support_point(vec_t d);
    vec_t p;
    logic [63:0] ax, az, s, qx, qz;
    ax = mag32(d.x);
    az = mag32(d.z);
    s = root_floor(ax * ax + az * az);
    p.x = '0;
    p.z = '0;
    if (s > {48'd0, cyl_eps}) begin
      qx = (ax * {33'd0, cyl_radius}) / s;
      qz = (az * {33'd0, cyl_radius}) / s;
      p.x = d.x[DATA_W-1] ? -qx[31:0] : qx[31:0];
      p.z = d.z[DATA_W-1] ? -qz[31:0] : qz[31:0];
    end
    p.y = d.y[DATA_W-1] ? -{1'b0, cyl_half_h} : {1'b0, cyl_half_h};
    return p;
  endfunction

  task automatic note_mismatch(string what, vec_t exp_p, vec_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)", what,
               exp_p.x, exp_p.y, exp_p.z, got.x, got.y, got.z);
  endtask

  // Receiver: random stall, check each transfer against the oldest expectation
  always @(posedge clk) begin
    vec_t got, exp_p;
    if (rst) begin
      pt_ch.ready <= 1'b0;
    end else begin
      if (pt_ch.valid && pt_ch.ready) begin
        got.x = pt_ch.point_x;
        got.y = pt_ch.point_y;
        got.z = pt_ch.point_z;
        if (pending_points.size() == 0) begin
          exp_p = '{default: '0};
          note_mismatch("unexpected point", exp_p, got);
        end else begin
          exp_p = pending_points.pop_front();
          if (got.x !== exp_p.x || got.y !== exp_p.y || got.z !== exp_p.z)
            note_mismatch("point mismatch", exp_p, got);
        end
      end
      pt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high after the transfer; the next idle cycle or drain drops it
  task automatic send_dir(vec_t d, bit known, vec_t pt);
    vec_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      dir_ch.valid <= 1'b0;
      @(posedge clk);
    end
    dir_ch.valid <= 1'b1;
    dir_ch.dir_x <= d.x;
    dir_ch.dir_y <= d.y;
    dir_ch.dir_z <= d.z;
    p = support_point(d);
    if (known && (p.x !== pt.x || p.y !== pt.y || p.z !== pt.z))
      note_mismatch("table row disagrees with prediction", pt, p);
    // Hold until the transfer happens
    do @(posedge clk); while (!dir_ch.ready);
    pending_points.insert(pending_points.size(), known ? pt : p);
  endtask

  task automatic drain_points();
    dir_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS:      cyl_radius = v[RADIUS_W-1:0];
      REG_HALF_HEIGHT: cyl_half_h = v[HALF_HEIGHT_W-1:0];
      REG_EPSILON:     cyl_eps    = v[EPSILON_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(65536 * 4) - 65536 * 2;
      2: return $urandom_range(8) - 4;
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic vec_t rand_dir();
    vec_t d;
    d.x = rand_comp();
    d.y = rand_comp();
    d.z = rand_comp();
    return d;
  endfunction

  dir_row_t dir_table[$];

  initial begin
    vec_t none;
    none = '{default: '0};
    dir_ch.valid = 1'b0;
    dir_ch.dir_x = '0;
    dir_ch.dir_y = '0;
    dir_ch.dir_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    cyl_radius = 31'd65536;
    cyl_half_h = 31'd32768;
    cyl_eps    = 16'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset settings: axes, zero, extremes, sign of y
    dir_table = '{
      '{'{32'sd0, 32'sd0, 32'sd0}, 1, '{32'sd0, 32'sd32768, 32'sd0}},
      '{'{32'sd65536, 32'sd0, 32'sd0}, 1, '{32'sd65536, 32'sd32768, 32'sd0}},
      '{'{-32'sd65536, -32'sd1, 32'sd0}, 1, '{-32'sd65536, -32'sd32768, 32'sd0}},
      '{'{32'sd0, 32'sd1, -32'sd65536}, 1, '{32'sd0, 32'sd32768, -32'sd65536}},
      '{'{32'sd1, 32'sd0, 32'sd0}, 1, '{32'sd0, 32'sd32768, 32'sd0}},
      '{'{32'sd2, 32'sd0, 32'sd0}, 1, '{32'sd65536, 32'sd32768, 32'sd0}},
      '{'{32'h8000_0000, 32'h8000_0000, 32'sd0}, 1,
        '{-32'sd65536, -32'sd32768, 32'sd0}},
      '{'{32'sd0, 32'h7fff_ffff, 32'h8000_0000}, 1,
        '{32'sd0, 32'sd32768, -32'sd65536}},
      '{'{32'h7fff_ffff, 32'sd5, 32'h7fff_ffff}, 0, none},
      '{'{32'h8000_0000, -32'sd5, 32'h8000_0000}, 0, none},
      '{'{32'hffff_ffff, 32'sd0, 32'sd1}, 0, none},
      '{'{32'sd3, 32'sd4, -32'sd4}, 0, none},
      '{'{-32'sd300000, 32'sd9, 32'sd400000}, 0, none}
    };
    foreach (dir_table[i]) send_dir(dir_table[i].dir, dir_table[i].known, dir_table[i].pt);
    drain_points();

    // Extreme settings: largest radius, half height and epsilon, then zeros
    write_reg(REG_RADIUS, 32'hffff_ffff);
    write_reg(REG_HALF_HEIGHT, 32'hffff_ffff);
    write_reg(REG_EPSILON, 32'hffff_ffff);
    write_reg(2'd3, 32'h1234_5678);
    send_dir('{32'h0000_ffff, -32'sd1, 32'sd0}, 1, '{32'sd0, -32'sh7fff_ffff, 32'sd0});
    send_dir('{32'h8000_0000, 32'sd0, 32'sd0}, 1, '{32'h8000_0001, 32'sh7fff_ffff, 32'sd0});
    repeat (4) send_dir(rand_dir(), 0, none);
    drain_points();
    write_reg(REG_RADIUS, 32'h0);
    write_reg(REG_HALF_HEIGHT, 32'h0);
    write_reg(REG_EPSILON, 32'h0);
    send_dir('{32'sd1, -32'sd1, 32'sd0}, 1, '{32'sd0, 32'sd0, 32'sd0});
    repeat (4) send_dir(rand_dir(), 0, none);
    drain_points();

    // Random phases with changing settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_RADIUS, $urandom_range(3) == 0 ? $urandom() : $urandom_range(65536 * 8));
      write_reg(REG_HALF_HEIGHT, $urandom());
      write_reg(REG_EPSILON, $urandom_range(1) ? $urandom_range(4) : $urandom());
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 80 : 0;
      recv_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 27 : 0;
      for (int n = 0; n < 305; n++) begin
        // Pause until everything has come out, once per phase
        if (n == 150) begin
          dir_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_points.size() != 0) @(posedge clk);
        end
        send_dir(rand_dir(), 0, none);
      end
      drain_points();
    end

    if (mismatches == 0)
      $display("cylinder_support_point_top verification clean");
    else
      $display("cylinder_support_point_top verification failed");
    $finish;
  end

  // Overall time limit
  initial begin
    #20ms;
    $display("cylinder_support_point_top verification failed");
    $finish;
  end
endmodule
